### rtl/servo_endstop_stall_search_top_assert.svh
// Assertion macros for the servo end-stop stall search block.
// Included by the top level; define ASSERT_OFF to drop the checks.
`ifndef SERVO_ENDSTOP_STALL_SEARCH_TOP_ASSERT_SVH
`define SERVO_ENDSTOP_STALL_SEARCH_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SESS_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SESS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SESS_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define SESS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/sess_pkg.sv
// Shared types, codes and step helpers of the servo end-stop stall search.
// No dependencies.
`timescale 1ns / 1ps

package sess_pkg;

  localparam int ANGLE_W    = 12;
  localparam int POS_W      = 14;
  localparam int CUR_W      = 16;
  localparam int STEP_W     = 10;
  localparam int FACT_W     = 8;
  localparam int CNT_W      = 6;
  localparam int KIND_W     = 2;
  localparam int MAX_RES    = 4;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;
  localparam int NRES_W     = 3;
  localparam int TDATA_W    = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WINDOW = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_FACT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES    = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [ANGLE_W-1:0]      pre;
    logic [ANGLE_W-1:0]      tgt;
    logic signed [POS_W-1:0] fmin;
    logic signed [POS_W-1:0] fmax;
    logic [CUR_W-1:0]        normal;
    logic [CUR_W-1:0]        stall;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [NRES_W-1:0]        n;
    result_t [MAX_RES-1:0]    res;
  } push_t;

  function automatic result_t mk_res(input logic [KIND_W-1:0] kind,
                                     input logic [ANGLE_W-1:0] pre,
                                     input logic [ANGLE_W-1:0] tgt);
    result_t r;
    r      = '0;
    r.kind = kind;
    r.pre  = pre;
    r.tgt  = tgt;
    return r;
  endfunction

  function automatic logic [ANGLE_W-1:0] step_down(input logic [ANGLE_W-1:0] x,
                                                   input logic [STEP_W-1:0]  eff,
                                                   input logic [ANGLE_W-1:0] lo);
    logic signed [POS_W-1:0] t;
    t = $signed({2'b00, x}) - $signed({4'b0000, eff});
    if (t < $signed({2'b00, lo})) return lo;
    return t[ANGLE_W-1:0];
  endfunction

  function automatic logic [ANGLE_W-1:0] step_up(input logic [ANGLE_W-1:0] x,
                                                 input logic [STEP_W-1:0]  eff,
                                                 input logic [ANGLE_W-1:0] hi);
    logic [ANGLE_W:0] t;
    t = {1'b0, x} + {3'b000, eff};
    if (t > {1'b0, hi}) return hi;
    return t[ANGLE_W-1:0];
  endfunction

endpackage

### rtl/sess_core.sv
// Calibration sequencer: input register, config registers, search state
// and result list generation. Depends on sess_pkg.
`timescale 1ns / 1ps

module sess_core import sess_pkg::*; #(
  parameter int CURRENT_BITS = 16,
  parameter int SWING        = 200
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_load,
  input  logic                  in_op,
  input  logic [CUR_W-1:0]      in_sample,
  output logic                  busy,
  output push_t                 push
);

  localparam logic [CUR_W-1:0] CUR_MASK = (CURRENT_BITS >= CUR_W) ? {CUR_W{1'b1}} :
      CUR_W'((32'd1 << CURRENT_BITS) - 32'd1);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_NORMAL = 2'd1;
  localparam logic [1:0] PH_DOWN   = 2'd2;
  localparam logic [1:0] PH_UP     = 2'd3;

  logic [ANGLE_W-1:0] low_r, high_r;
  logic [STEP_W-1:0]  step_size_r;
  logic [FACT_W-1:0]  fact_r;
  logic [CNT_W-1:0]   spw_r;

  logic               in_valid_r;
  logic               op_r;
  logic [CUR_W-1:0]   sample_r;

  logic [1:0]              phase_r, phase_nxt;
  logic [ANGLE_W-1:0]      step_r, step_nxt;
  logic [CUR_W-1:0]        peak_r, peak_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CUR_W-1:0]        normal_r, normal_nxt;
  logic [CUR_W-1:0]        stall_r, stall_nxt;
  logic signed [POS_W-1:0] min_r, min_nxt;
  logic signed [POS_W-1:0] max_r, max_nxt;

  logic [ANGLE_W:0]        csum;
  logic [ANGLE_W-1:0]      centre;
  logic [STEP_W-1:0]       eff;
  logic signed [POS_W-1:0] from_w;
  logic [ANGLE_W:0]        to_w;
  logic [ANGLE_W-1:0]      win_from, win_to;
  logic [CUR_W-1:0]        peak_new;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    win_end;
  logic [23:0]             thr;
  logic [23:0]             pk16;
  logic                    stall_hit;
  logic [CUR_W:0]          stall_sum;
  logic [ANGLE_W-1:0]      dn_c, up_c, dn_s, up_s;
  logic [ANGLE_W-1:0]      min_sat;
  logic                    do_sd, do_su, do_fin;
  logic [NRES_W-1:0]       n;
  result_t [MAX_RES-1:0]   res;
  result_t                 done_res;

  assign csum     = {1'b0, low_r} + {1'b0, high_r};
  assign centre   = csum[ANGLE_W:1];
  assign eff      = (step_size_r == '0) ? STEP_W'(1) : step_size_r;
  assign from_w   = $signed({2'b00, centre}) - $signed(POS_W'(SWING));
  assign to_w     = {1'b0, centre} + (ANGLE_W+1)'(SWING);
  assign win_from = (from_w < $signed({2'b00, low_r})) ? low_r : from_w[ANGLE_W-1:0];
  assign win_to   = (to_w > {1'b0, high_r}) ? high_r : to_w[ANGLE_W-1:0];
  assign peak_new = (sample_r > peak_r) ? sample_r : peak_r;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign win_end  = (cnt_inc >= spw_r);
  assign thr      = normal_r * fact_r;
  assign pk16     = {4'b0000, peak_new, 4'b0000};
  assign stall_hit = (pk16 > thr);
  assign stall_sum = {1'b0, stall_r} + {1'b0, peak_new};
  assign dn_c     = step_down(centre, eff, low_r);
  assign up_c     = step_up(centre, eff, high_r);
  assign dn_s     = step_down(step_r, eff, low_r);
  assign up_s     = step_up(step_r, eff, high_r);
  assign busy     = in_valid_r;

  always_comb begin
    phase_nxt  = phase_r;
    step_nxt   = step_r;
    peak_nxt   = peak_r;
    cnt_nxt    = cnt_r;
    normal_nxt = normal_r;
    stall_nxt  = stall_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    res        = '0;
    n          = '0;
    do_sd      = 1'b0;
    do_su      = 1'b0;
    do_fin     = 1'b0;
    min_sat    = '0;
    done_res   = '0;

    if (in_valid_r) begin
      if (op_r == OP_START) begin
        if (phase_r == PH_IDLE) begin
          res[0]    = mk_res(KIND_MOVE, '0, centre);
          res[1]    = mk_res(KIND_WINDOW, win_from, win_to);
          n         = NRES_W'(2);
          phase_nxt = PH_NORMAL;
          peak_nxt  = '0;
          cnt_nxt   = '0;
        end
      end else if (phase_r != PH_IDLE) begin
        peak_nxt = peak_new;
        cnt_nxt  = cnt_inc;
        if (win_end) begin
          unique case (phase_r)
            PH_NORMAL: begin
              normal_nxt = peak_new;
              do_sd      = 1'b1;
            end
            PH_DOWN: begin
              if (stall_hit) begin
                min_nxt   = $signed({2'b00, step_r}) + $signed({4'b0000, eff});
                stall_nxt = peak_new;
                do_su     = 1'b1;
              end else if (step_r > low_r) begin
                res[0]   = mk_res(KIND_WINDOW, step_r, dn_s);
                n        = NRES_W'(1);
                step_nxt = dn_s;
                peak_nxt = '0;
                cnt_nxt  = '0;
              end else begin
                min_nxt = $signed({2'b00, low_r});
                do_su   = 1'b1;
              end
            end
            PH_UP: begin
              if (stall_hit) begin
                max_nxt   = $signed({2'b00, step_r}) - $signed({4'b0000, eff});
                stall_nxt = stall_sum[CUR_W:1];
                do_fin    = 1'b1;
              end else if (step_r < high_r) begin
                res[0]   = mk_res(KIND_WINDOW, step_r, up_s);
                n        = NRES_W'(1);
                step_nxt = up_s;
                peak_nxt = '0;
                cnt_nxt  = '0;
              end else begin
                max_nxt = $signed({2'b00, high_r});
                do_fin  = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (do_sd) begin
      res[n[1:0]] = mk_res(KIND_MOVE, '0, centre);
      n = n + NRES_W'(1);
      if (centre > low_r) begin
        res[n[1:0]] = mk_res(KIND_WINDOW, centre, dn_c);
        n         = n + NRES_W'(1);
        step_nxt  = dn_c;
        phase_nxt = PH_DOWN;
        peak_nxt  = '0;
        cnt_nxt   = '0;
      end else begin
        min_nxt = $signed({2'b00, low_r});
        do_su   = 1'b1;
      end
    end

    if (do_su) begin
      res[n[1:0]] = mk_res(KIND_MOVE, '0, centre);
      n = n + NRES_W'(1);
      if (centre < high_r) begin
        res[n[1:0]] = mk_res(KIND_WINDOW, centre, up_c);
        n         = n + NRES_W'(1);
        step_nxt  = up_c;
        phase_nxt = PH_UP;
        peak_nxt  = '0;
        cnt_nxt   = '0;
      end else begin
        max_nxt = $signed({2'b00, high_r});
        do_fin  = 1'b1;
      end
    end

    if (do_fin) begin
      if (min_nxt[POS_W-1]) begin
        min_sat = '0;
      end else if (min_nxt[ANGLE_W]) begin
        min_sat = {ANGLE_W{1'b1}};
      end else begin
        min_sat = min_nxt[ANGLE_W-1:0];
      end
      res[n[1:0]] = mk_res(KIND_MOVE, '0, min_sat);
      n = n + NRES_W'(1);
      done_res        = mk_res(KIND_DONE, '0, '0);
      done_res.fmin   = min_nxt;
      done_res.fmax   = max_nxt;
      done_res.normal = normal_nxt;
      done_res.stall  = stall_nxt;
      res[n[1:0]] = done_res;
      n = n + NRES_W'(1);
      phase_nxt = PH_IDLE;
    end

    if (n != '0) begin
      res[2'(n - NRES_W'(1))].last = 1'b1;
    end
  end

  assign push.n   = n;
  assign push.res = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= '0;
      high_r      <= ANGLE_W'(1800);
      step_size_r <= STEP_W'(50);
      fact_r      <= FACT_W'(24);
      spw_r       <= CNT_W'(20);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_ANGLE_LOW:  low_r       <= cfg_wdata[ANGLE_W-1:0];
        REG_ANGLE_HIGH: high_r      <= cfg_wdata[ANGLE_W-1:0];
        REG_STEP_SIZE:  step_size_r <= cfg_wdata[STEP_W-1:0];
        REG_STALL_FACT: fact_r      <= cfg_wdata[FACT_W-1:0];
        REG_SAMPLES:    spw_r       <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= PH_IDLE;
      step_r     <= '0;
      peak_r     <= '0;
      cnt_r      <= '0;
      normal_r   <= CUR_W'(500);
      stall_r    <= CUR_W'(2000);
      min_r      <= '0;
      max_r      <= POS_W'(1800);
    end else begin
      in_valid_r <= in_load;
      phase_r    <= phase_nxt;
      step_r     <= step_nxt;
      peak_r     <= peak_nxt;
      cnt_r      <= cnt_nxt;
      normal_r   <= normal_nxt;
      stall_r    <= stall_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      op_r     <= in_op;
      sample_r <= in_sample & CUR_MASK;
    end
  end

endmodule

### rtl/sess_fifo.sv
// Result queue: takes up to four results per cycle, hands out one per
// transaction. Depends on sess_pkg.
`timescale 1ns / 1ps

module sess_fifo import sess_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  push_t              push,
  input  logic               pop,
  output logic               head_valid,
  output result_t            head,
  output logic [FIFO_CW-1:0] count
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   cnt_r;

  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];
  assign count      = cnt_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (NRES_W'(i) < push.n) begin
        mem[FIFO_AW'(wr_ptr_r + FIFO_AW'(i))] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push.n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + FIFO_CW'(push.n) - FIFO_CW'(pop);
    end
  end

endmodule

### rtl/servo_endstop_stall_search_top.sv
// Top level of the servo end-stop stall search: core sequencer and
// result queue. Depends on sess_pkg, sess_core, sess_fifo and the assert header.
`timescale 1ns / 1ps
`include "servo_endstop_stall_search_top_assert.svh"

// Usage:
// - Program the five registers through cfg_wr_en/cfg_addr/cfg_wdata while
//   idle; a write lands at the clock edge where cfg_wr_en is high.
// - Send commands on the in_ stream: in_tuser selects start (0) or current
//   sample (1), in_tdata carries the sample.
// - Each input transaction yields zero to four results on the out_ stream;
//   out_tuser gives the result kind, out_tlast marks the final result
//   caused by that transaction.
// - The first result of an input transaction passes the input register, then
//   the result queue, before it is valid on out_tvalid.
// - Throughput: one input per cycle while in_tready is high; a sample that
//   does not close a window yields nothing. The output side moves one result
//   per cycle while out_tready is high.
// - in_tready drops while the queued results plus those of the transaction
//   in the input register exceed four; a stalled receiver therefore backs
//   up the input side after at most two bursts.
// - Synchronous reset: registers return to defaults, search goes idle,
//   queue empties. No clearing pass.

module servo_endstop_stall_search_top import sess_pkg::*; #(
  parameter int CURRENT_BITS = 16,
  parameter int SWING        = 200
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CUR_W-1:0]      in_tdata,   // [15:0] current_sample
  input  logic                  in_tuser,   // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [11:0] pre_angle, [23:12] target_angle, [37:24] found_min,
  // [51:38] found_max, [67:52] normal_level, [83:68] stall_level,
  // [87:84] zero
  output logic [TDATA_W-1:0]    out_tdata,
  output logic [KIND_W-1:0]     out_tuser,  // [1:0] result_kind
  output logic                  out_tlast
);

  logic               core_busy;
  push_t              core_push;
  logic               fifo_valid;
  result_t            fifo_head;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic [FIFO_CW-1:0] pend;
  logic               in_accept;
  logic               pop;

  assign pend      = fifo_cnt + (core_busy ? FIFO_CW'(core_push.n) : '0);
  assign in_tready = (pend <= FIFO_CW'(FIFO_DEPTH - MAX_RES));
  assign in_accept = in_tvalid & in_tready;
  assign pop       = fifo_valid & out_tready;

  sess_core #(
    .CURRENT_BITS (CURRENT_BITS),
    .SWING        (SWING)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_load   (in_accept),
    .in_op     (in_tuser),
    .in_sample (in_tdata),
    .busy      (core_busy),
    .push      (core_push)
  );

  sess_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (core_push),
    .pop        (pop),
    .head_valid (fifo_valid),
    .head       (fifo_head),
    .count      (fifo_cnt)
  );

  assign out_tvalid = fifo_valid;
  assign out_tlast  = fifo_head.last;
  assign out_tuser  = fifo_head.kind;
  assign out_tdata  = {4'b0000, fifo_head.stall, fifo_head.normal, fifo_head.fmax,
                       fifo_head.fmin, fifo_head.tgt, fifo_head.pre};

  `SESS_ASSERT_RST(a_queue_no_overflow, clk, rst_n, fifo_cnt <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")
  `SESS_ASSERT_RST(a_pop_count, clk, rst_n, (pop && core_push.n == '0) |=> (fifo_cnt == $past(fifo_cnt) - FIFO_CW'(1)), "queue count lost a transaction")
  `SESS_ASSERT_ALWAYS(a_reset_empty, clk, (!rst_n) |=> (!out_tvalid), "results present after reset")

endmodule

### bench/tb.sv
// Testbench for servo_endstop_stall_search_top: drives start and current-sample
// transactions, predicts every move, window and done result, and checks the out_ stream.
// Depends on sess_pkg and the RTL of the top level.
`timescale 1ns / 1ps

module tb;
  import sess_pkg::*;

  localparam int SWING_ANGLE = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {CAL_IDLE, CAL_NORMAL, CAL_DOWN, CAL_UP} cal_phase_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [CUR_W-1:0]      in_tdata;   // [15:0] current_sample
  logic                  in_tuser;   // [0] opcode
  logic                  out_tvalid;
  logic                  out_tready;
  // [11:0] pre, [23:12] target, [37:24] min, [51:38] max,
  // [67:52] normal, [83:68] stall, [87:84] zero
  logic [TDATA_W-1:0]    out_tdata;
  logic [KIND_W-1:0]     out_tuser;  // [1:0] kind
  logic                  out_tlast;

  // calibration model state
  int m_lo, m_hi, m_step, m_fact, m_spw;
  cal_phase_t cal_phase;
  int step_ang, win_peak, win_cnt, normal_lvl, stall_lvl, min_ang, max_ang;
  result_t step_results [MAX_RES];
  int step_n;
  result_t expected_moves [$];

  int send_idle_pct, recv_idle_pct;
  int errors, n_items, n_checked, n_settings, n_calibrations;
  int unsigned cycle_count;

  servo_endstop_stall_search_top #(
    .CURRENT_BITS(CUR_W),
    .SWING(SWING_ANGLE)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("[servo_endstop_stall_search_top] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------- model
  function automatic int centre_angle();
    return (m_lo + m_hi) / 2;
  endfunction

  function automatic int eff_step();
    return (m_step == 0) ? 1 : m_step;
  endfunction

  function automatic bit stall_seen(input int peak);
    return longint'(peak) * 16 > longint'(normal_lvl) * m_fact;
  endfunction

  function automatic void queue_result(input logic [KIND_W-1:0] kind, input int pre,
                                       input int tgt, input bit report);
    result_t r;
    r      = '0;
    r.kind = kind;
    r.pre  = pre[ANGLE_W-1:0];
    r.tgt  = tgt[ANGLE_W-1:0];
    if (report) begin
      r.fmin   = min_ang[POS_W-1:0];
      r.fmax   = max_ang[POS_W-1:0];
      r.normal = normal_lvl[CUR_W-1:0];
      r.stall  = stall_lvl[CUR_W-1:0];
    end
    if (step_n < MAX_RES) begin
      step_results[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic void open_window(input int from, input int to);
    win_peak = 0;
    win_cnt  = 0;
    queue_result(KIND_WINDOW, from, to, 1'b0);
  endfunction

  function automatic void finish_cal();
    int t;
    t = min_ang;
    if (t > 4095) t = 4095;
    if (t < 0) t = 0;
    queue_result(KIND_MOVE, 0, t, 1'b0);
    queue_result(KIND_DONE, 0, 0, 1'b1);
    cal_phase = CAL_IDLE;
    n_calibrations++;
  endfunction

  function automatic void step_up_window();
    int prev;
    int nxt;
    prev = step_ang;
    nxt  = prev + eff_step();
    if (nxt > m_hi) nxt = m_hi;
    step_ang  = nxt;
    cal_phase = CAL_UP;
    open_window(prev, nxt);
  endfunction

  function automatic void begin_up_search();
    queue_result(KIND_MOVE, 0, centre_angle(), 1'b0);
    step_ang = centre_angle();
    if (step_ang < m_hi) begin
      step_up_window();
    end else begin
      max_ang = m_hi;
      finish_cal();
    end
  endfunction

  function automatic void step_down_window();
    int prev;
    int nxt;
    prev = step_ang;
    nxt  = prev - eff_step();
    if (nxt < m_lo) nxt = m_lo;
    step_ang  = nxt;
    cal_phase = CAL_DOWN;
    open_window(prev, nxt);
  endfunction

  function automatic void begin_down_search();
    queue_result(KIND_MOVE, 0, centre_angle(), 1'b0);
    step_ang = centre_angle();
    if (step_ang > m_lo) begin
      step_down_window();
    end else begin
      min_ang = m_lo;
      begin_up_search();
    end
  endfunction

  function automatic void calib_advance(input logic op, input logic [CUR_W-1:0] sample);
    int c;
    int from;
    int to;
    int peak;
    step_n = 0;
    if (op == OP_START) begin
      if (cal_phase == CAL_IDLE) begin
        c    = centre_angle();
        from = c - SWING_ANGLE;
        to   = c + SWING_ANGLE;
        if (from < m_lo) from = m_lo;
        if (to > m_hi) to = m_hi;
        queue_result(KIND_MOVE, 0, c, 1'b0);
        cal_phase = CAL_NORMAL;
        open_window(from, to);
      end
    end else if (cal_phase != CAL_IDLE) begin
      if (int'(sample) > win_peak) win_peak = int'(sample);
      win_cnt = (win_cnt + 1) & 63;
      if (win_cnt >= m_spw) begin
        peak = win_peak;
        case (cal_phase)
          CAL_NORMAL: begin
            normal_lvl = peak;
            begin_down_search();
          end
          CAL_DOWN: begin
            if (stall_seen(peak)) begin
              min_ang   = step_ang + eff_step();
              stall_lvl = peak;
              begin_up_search();
            end else if (step_ang > m_lo) begin
              step_down_window();
            end else begin
              min_ang = m_lo;
              begin_up_search();
            end
          end
          CAL_UP: begin
            if (stall_seen(peak)) begin
              max_ang   = step_ang - eff_step();
              stall_lvl = (stall_lvl + peak) / 2;
              finish_cal();
            end else if (step_ang < m_hi) begin
              step_up_window();
            end else begin
              max_ang = m_hi;
              finish_cal();
            end
          end
          default: ;
        endcase
      end
    end
    if (step_n > 0) step_results[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_moves.push_back(step_results[i]);
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_moves.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_moves.pop_front();
        n_checked++;
        check_field("result_kind", int'(want.kind), int'(out_tuser));
        check_field("pre_angle", int'(want.pre), int'(out_tdata[11:0]));
        check_field("target_angle", int'(want.tgt), int'(out_tdata[23:12]));
        check_field("found_min", int'(want.fmin), int'($signed(out_tdata[37:24])));
        check_field("found_max", int'(want.fmax), int'($signed(out_tdata[51:38])));
        check_field("normal_level", int'(want.normal), int'(out_tdata[67:52]));
        check_field("stall_level", int'(want.stall), int'(out_tdata[83:68]));
        check_field("last", int'(want.last), int'(out_tlast));
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input logic op, input logic [CUR_W-1:0] sample);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = sample;
    do @(posedge clk); while (!in_tready);
    calib_advance(op, sample);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_moves.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input int lo, input int hi, input int step, input int fact,
                               input int spw);
    int vals [5];
    logic [CFG_IDX_W-1:0] regs [5];
    vals = '{lo, hi, step, fact, spw};
    regs = '{REG_ANGLE_LOW, REG_ANGLE_HIGH, REG_STEP_SIZE, REG_STALL_FACT, REG_SAMPLES};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en = 1'b1;
      cfg_addr  = regs[i];
      cfg_wdata = vals[i][CFG_DATA_W-1:0];
      @(posedge clk);
      case (cfg_addr)
        REG_ANGLE_LOW:  m_lo   = int'(cfg_wdata[ANGLE_W-1:0]);
        REG_ANGLE_HIGH: m_hi   = int'(cfg_wdata[ANGLE_W-1:0]);
        REG_STEP_SIZE:  m_step = int'(cfg_wdata[STEP_W-1:0]);
        REG_STALL_FACT: m_fact = int'(cfg_wdata[FACT_W-1:0]);
        REG_SAMPLES:    m_spw  = int'(cfg_wdata[CNT_W-1:0]);
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_wr_en = 1'b0;
    n_settings++;
  endtask

  task automatic apply_random_setting();
    int lo;
    int hi;
    int step;
    int spw;
    case ($urandom_range(0, 9))
      0: begin
        lo = $urandom_range(0, 20);
        hi = lo + $urandom_range(0, 40);
      end
      1, 2: begin
        lo = $urandom_range(0, 3600);
        hi = $urandom_range(0, 3600);
      end
      default: begin
        lo = $urandom_range(0, 3600);
        hi = $urandom_range(lo, 3600);
      end
    endcase
    step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 900);
    spw  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    apply_setting(lo, hi, step, $urandom_range(16, 255), spw);
  endtask

  function automatic logic [CUR_W-1:0] pick_sample(input bit force_stall);
    int th;
    if (cal_phase == CAL_NORMAL) return CUR_W'($urandom_range(0, 4095));
    th = normal_lvl * m_fact / 16;
    if (th < 65535 && (force_stall || $urandom_range(0, 99) < 15))
      return CUR_W'($urandom_range(th + 1, 65535));
    return CUR_W'($urandom_range(0, (th < 65535) ? th : 65535));
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_no_stall_full_range();
    apply_setting(0, 4095, 900, 16, 1);
    send_item(OP_SAMPLE, 16'hFFFF);
    send_item(OP_START, 16'h0000);
    send_item(OP_SAMPLE, 16'hFFFF);
    send_item(OP_SAMPLE, 16'hAAAA);
    send_item(OP_SAMPLE, 16'h5555);
    send_item(OP_SAMPLE, 16'h0000);
    send_item(OP_SAMPLE, 16'hFFFF);
    send_item(OP_SAMPLE, 16'h8001);
    send_item(OP_SAMPLE, 16'h7FFE);
    wait_drained();
  endtask

  task automatic test_stalls_both_sides();
    apply_setting(100, 1000, 900, 255, 1);
    send_item(OP_START, 16'h1234);
    send_item(OP_START, 16'hFFFF);
    send_item(OP_SAMPLE, 16'd1000);
    send_item(OP_SAMPLE, 16'hFFFF);
    send_item(OP_SAMPLE, 16'hF000);
    wait_drained();
  endtask

  task automatic test_degenerate_range();
    apply_setting(1800, 1800, 0, 24, 0);
    send_item(OP_START, 16'h0000);
    send_item(OP_SAMPLE, 16'd123);
    wait_drained();
    apply_setting(1798, 1802, 0, 16, 0);
    send_item(OP_START, 16'h0000);
    send_item(OP_SAMPLE, 16'd100);
    send_item(OP_SAMPLE, 16'd5000);
    send_item(OP_SAMPLE, 16'd3000);
    wait_drained();
  endtask

  task automatic test_final_move_saturation();
    apply_setting(3300, 4095, 900, 32, 2);
    send_item(OP_START, 16'h0000);
    send_item(OP_SAMPLE, 16'd10);
    send_item(OP_SAMPLE, 16'd20);
    send_item(OP_SAMPLE, 16'd50);
    send_item(OP_SAMPLE, 16'd0);
    send_item(OP_SAMPLE, 16'd0);
    send_item(OP_SAMPLE, 16'd0);
    wait_drained();
  endtask

  task automatic test_long_window();
    apply_setting(3600, 3600, 900, 255, 63);
    send_item(OP_START, 16'h0000);
    repeat (63) send_item(OP_SAMPLE, CUR_W'($urandom_range(0, 65535)));
    wait_drained();
  endtask

  task automatic test_random_search(input int n_target, input bit with_pause);
    int sent;
    bit pause_pending;
    sent          = 0;
    pause_pending = with_pause;
    apply_random_setting();
    while (sent < n_target) begin
      if (cal_phase == CAL_IDLE) begin
        if ($urandom_range(0, 3) == 0) begin
          wait_drained();
          apply_random_setting();
        end
        if ($urandom_range(0, 99) < 8) begin
          send_item(OP_SAMPLE, CUR_W'($urandom_range(0, 65535)));
        end else begin
          send_item(OP_START, CUR_W'($urandom_range(0, 65535)));
          sent++;
        end
      end else if ($urandom_range(0, 99) < 4) begin
        send_item(OP_START, CUR_W'($urandom_range(0, 65535)));
      end else begin
        send_item(OP_SAMPLE, pick_sample(1'b0));
        sent++;
      end
      if (pause_pending && sent >= n_target / 2) begin
        wait_drained();
        pause_pending = 1'b0;
      end
    end
    while (cal_phase != CAL_IDLE) send_item(OP_SAMPLE, pick_sample(1'b1));
    wait_drained();
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_addr   = REG_ANGLE_LOW;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tuser   = OP_START;
    in_tdata   = '0;
    out_tready = 1'b0;
    m_lo       = 0;
    m_hi       = 1800;
    m_step     = 50;
    m_fact     = 24;
    m_spw      = 20;
    cal_phase  = CAL_IDLE;
    step_ang   = 0;
    win_peak   = 0;
    win_cnt    = 0;
    normal_lvl = 500;
    stall_lvl  = 2000;
    min_ang    = 0;
    max_ang    = 1800;
    send_idle_pct  = 35;
    recv_idle_pct  = 85;
    errors         = 0;
    n_items        = 0;
    n_checked      = 0;
    n_settings     = 0;
    n_calibrations = 0;
    cycle_count    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_no_stall_full_range();
    test_stalls_both_sides();
    test_degenerate_range();
    test_final_move_saturation();
    test_random_search(30, 1'b1);

    send_idle_pct = 85;
    recv_idle_pct = 35;
    test_random_search(30, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_long_window();
    test_random_search(30, 1'b0);

    wait_drained();
    $display("Run covered %0d input transactions under %0d register settings, %0d calibrations.",
             n_items, n_settings, n_calibrations);
    $display("Checked %0d result transactions, %0d mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("[servo_endstop_stall_search_top] OK");
    end else begin
      $display("[servo_endstop_stall_search_top] ERROR");
    end
    $finish;
  end

endmodule
